/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HRWL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRWL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hrwl_pkg.sv */
// ----------------------------------------------------------------------------
// hrwl_pkg
// Types, codes and helpers shared by the hex record window loader
// ----------------------------------------------------------------------------
package hrwl_pkg;

  // output address field width
  localparam int ADDR_W = 26;

  // parse phases
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_SSEL   = 4'd1;
  localparam logic [3:0] PH_COUNT  = 4'd2;
  localparam logic [3:0] PH_ADDR   = 4'd3;
  localparam logic [3:0] PH_TYPE   = 4'd4;
  localparam logic [3:0] PH_DATA   = 4'd5;
  localparam logic [3:0] PH_OFFSET = 4'd6;
  localparam logic [3:0] PH_RAW    = 4'd7;
  localparam logic [3:0] PH_SKIP   = 4'd8;

  // record forms
  localparam logic [2:0] FM_NONE = 3'd0;
  localparam logic [2:0] FM_S1   = 3'd1;
  localparam logic [2:0] FM_S2   = 3'd2;
  localparam logic [2:0] FM_S3   = 3'd3;
  localparam logic [2:0] FM_IHEX = 3'd4;
  localparam logic [2:0] FM_RAW  = 3'd5;

  // intel record types
  localparam logic [7:0] IT_DATA    = 8'd0;
  localparam logic [7:0] IT_SEGMENT = 8'd2;
  localparam logic [7:0] IT_LINEAR  = 8'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_START  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] CFG_DEST_BASE     = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;

  // events from the parser to the address unit for one item
  typedef struct packed {
    logic        eos;
    logic        addr_load;
    logic        add_offset;
    logic        offset_load;
    logic [31:0] value;
    logic        data_byte;
    logic        raw_byte;
    logic [7:0]  data;
    logic        raw_inc;
  } hrwl_evt_t;

  // result of one item
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [32:0]       span;
  } hrwl_res_t;

  // hex digit value, bit 4 set for a non-hex character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      d = 8'h10;
    end
    return d[4:0];
  endfunction

endpackage

/* sv/hrwl_parse.sv */
// ----------------------------------------------------------------------------
// hrwl_parse
// Record text parser: tracks line position and fields, emits address events
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrwl_parse import hrwl_pkg::*; #(
  parameter int MAX_LINE_CHARS = 200
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       req_type,
  input  logic [7:0] ch,
  output hrwl_evt_t  evt
);

  localparam int PosW = $clog2(MAX_LINE_CHARS);

  logic [3:0]      phase, phase_next;
  logic [2:0]      form, form_next;
  logic [PosW-1:0] pos, pos_next;
  logic [7:0]      byte_count, byte_count_next;
  logic [7:0]      record_type, record_type_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic [31:0]     acc, acc_next;

  logic [4:0]      hex;
  logic [3:0]      h;
  logic [31:0]     acc_shift;
  logic            is_ihex;
  logic            clear_all;
  logic [PosW-1:0] addr_end;
  logic [7:0]      s_sub;

  // field decode helpers
  always_comb begin
    hex       = hex_digit(ch);
    h         = hex[3:0];
    acc_shift = {acc[27:0], h};
    is_ihex   = (form == FM_IHEX);
    s_sub     = 8'({5'd0, form}) + 8'd2;
    unique case (form)
      FM_S1:   addr_end = PosW'(7);
      FM_S2:   addr_end = PosW'(9);
      FM_S3:   addr_end = PosW'(11);
      default: addr_end = PosW'(6);
    endcase
  end

  // per-item parse step
  always_comb begin
    phase_next       = phase;
    form_next        = form;
    pos_next         = pos;
    byte_count_next  = byte_count;
    record_type_next = record_type;
    high_nibble_next = high_nibble;
    acc_next         = acc;
    clear_all        = 1'b0;
    evt              = '0;

    if (step) begin
      if (req_type) begin
        evt.eos   = 1'b1;
        clear_all = 1'b1;
      end else if (ch == CH_CR || ch == CH_LF) begin
        evt.raw_inc = (form == FM_RAW);
        clear_all   = 1'b1;
      end else begin
        unique case (phase)
          PH_START: begin
            if (ch == CH_S) begin
              phase_next = PH_SSEL;
            end else if (ch == CH_COLON) begin
              form_next  = FM_IHEX;
              phase_next = PH_COUNT;
            end else if (ch == CH_HASH) begin
              form_next  = FM_RAW;
              phase_next = PH_RAW;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_SSEL: begin
            if (ch == CH_ONE) begin
              form_next  = FM_S1;
              phase_next = PH_COUNT;
            end else if (ch == CH_TWO) begin
              form_next  = FM_S2;
              phase_next = PH_COUNT;
            end else if (ch == CH_THREE) begin
              form_next  = FM_S3;
              phase_next = PH_COUNT;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            phase_next = PH_SKIP;
          end
          default: begin
            if (hex[4]) begin
              phase_next = PH_SKIP;
            end else begin
              acc_next = acc_shift;
              unique case (phase)
                // byte count field
                PH_COUNT: begin
                  if (pos == (is_ihex ? PosW'(2) : PosW'(3))) begin
                    byte_count_next = acc_shift[7:0];
                    acc_next        = '0;
                    phase_next      = PH_ADDR;
                  end
                end
                // load address field
                PH_ADDR: begin
                  if (pos == addr_end) begin
                    evt.addr_load = 1'b1;
                    evt.value     = acc_shift;
                    acc_next      = '0;
                    if (is_ihex) begin
                      phase_next = PH_TYPE;
                    end else if (byte_count > s_sub) begin
                      byte_count_next = byte_count - s_sub;
                      phase_next      = PH_DATA;
                    end else begin
                      byte_count_next = '0;
                      phase_next      = PH_SKIP;
                    end
                  end
                end
                // intel record type
                PH_TYPE: begin
                  if (pos == PosW'(8)) begin
                    record_type_next = acc_shift[7:0];
                    acc_next         = '0;
                    if (acc_shift[7:0] == IT_DATA) begin
                      evt.add_offset = 1'b1;
                      phase_next     = (byte_count != 8'd0) ? PH_DATA : PH_SKIP;
                    end else if (acc_shift[7:0] == IT_SEGMENT ||
                                 acc_shift[7:0] == IT_LINEAR) begin
                      phase_next = PH_OFFSET;
                    end else begin
                      phase_next = PH_SKIP;
                    end
                  end
                end
                // data bytes, high nibble first
                PH_DATA: begin
                  if (pos[0] == is_ihex) begin
                    high_nibble_next = h;
                  end else begin
                    evt.data_byte   = 1'b1;
                    evt.data        = {high_nibble, h};
                    byte_count_next = byte_count - 8'd1;
                    if (byte_count == 8'd1) begin
                      phase_next = PH_SKIP;
                    end
                  end
                end
                // segment or linear offset
                PH_OFFSET: begin
                  if (pos == PosW'(12)) begin
                    evt.offset_load = 1'b1;
                    evt.value       = (record_type == IT_SEGMENT) ?
                                      {12'd0, acc_shift[15:0], 4'd0} :
                                      {acc_shift[15:0], 16'd0};
                    phase_next      = PH_SKIP;
                  end
                end
                // raw byte line
                PH_RAW: begin
                  if (pos == PosW'(1)) begin
                    high_nibble_next = h;
                  end else begin
                    evt.raw_byte = 1'b1;
                    evt.data     = {high_nibble, h};
                    phase_next   = PH_SKIP;
                  end
                end
                default: begin
                  phase_next = PH_SKIP;
                end
              endcase
            end
          end
        endcase

        // position count and long line cut
        pos_next = pos + PosW'(1);
        if (pos == PosW'(MAX_LINE_CHARS - 2)) begin
          evt.raw_inc = (form == FM_RAW);
          clear_all   = 1'b1;
        end
      end
    end

    if (clear_all) begin
      phase_next       = PH_START;
      form_next        = FM_NONE;
      pos_next         = '0;
      byte_count_next  = '0;
      record_type_next = '0;
      high_nibble_next = '0;
      acc_next         = '0;
    end
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      form        <= FM_NONE;
      pos         <= '0;
      byte_count  <= '0;
      record_type <= '0;
      high_nibble <= '0;
      acc         <= '0;
    end else begin
      phase       <= phase_next;
      form        <= form_next;
      pos         <= pos_next;
      byte_count  <= byte_count_next;
      record_type <= record_type_next;
      high_nibble <= high_nibble_next;
      acc         <= acc_next;
    end
  end

  `HRWL_ASSERT_IMP(a_data_count, phase == PH_DATA, byte_count != 8'd0, "data phase with no bytes left")
  `HRWL_ASSERT_IMP(a_pos_bound, 1'b1, pos <= PosW'(MAX_LINE_CHARS - 2), "line position past limit")
  `HRWL_ASSERT_IMP(a_one_write, 1'b1, $onehot0({evt.eos, evt.data_byte, evt.raw_byte}), "several results in one item")

endmodule

/* sv/hrwl_addr.sv */
// ----------------------------------------------------------------------------
// hrwl_addr
// Address tracking, window test, relocation and span report
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrwl_addr import hrwl_pkg::*; #(
  parameter int MEM_ADDR_BITS = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  hrwl_evt_t   evt,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output hrwl_res_t   res
);

  localparam int MaskBits = (MEM_ADDR_BITS < ADDR_W) ? MEM_ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] MemMask = ADDR_W'((64'd1 << MaskBits) - 64'd1);

  logic [31:0]       window_start;
  logic [31:0]       window_length;
  logic [ADDR_W-1:0] dest_base;
  logic [31:0]       cur, cur_next;
  logic [31:0]       ext, ext_next;
  logic [31:0]       lowest, lowest_next;
  logic [31:0]       highest, highest_next;

  logic [32:0]       off;
  logic              in_win;
  logic [ADDR_W-1:0] win_addr;
  logic [ADDR_W-1:0] raw_addr;
  logic [32:0]       span_val;

  // window test and relocation
  always_comb begin
    off      = {1'b0, cur} - {1'b0, window_start};
    in_win   = !off[32] && (off[31:0] < window_length);
    win_addr = (off[ADDR_W-1:0] + dest_base) & MemMask;
    raw_addr = (cur[ADDR_W-1:0] + dest_base) & MemMask;
    span_val = (highest > lowest) ? ({1'b0, highest} - {1'b0, lowest} + 33'd1) : '0;
  end

  // result and address state update
  always_comb begin
    res          = '0;
    cur_next     = cur;
    ext_next     = ext;
    lowest_next  = lowest;
    highest_next = highest;

    if (evt.eos) begin
      res.valid    = 1'b1;
      res.kind     = 1'b1;
      res.span     = span_val;
      cur_next     = '0;
      ext_next     = '0;
      lowest_next  = '1;
      highest_next = '0;
    end else if (evt.addr_load) begin
      cur_next = evt.value;
    end else if (evt.add_offset) begin
      cur_next = cur + ext;
    end else if (evt.data_byte) begin
      cur_next = cur + 32'd1;
      if (in_win) begin
        res.valid = 1'b1;
        res.addr  = win_addr;
        res.data  = evt.data;
        if (cur < lowest) begin
          lowest_next = cur;
        end
        if (cur > highest) begin
          highest_next = cur;
        end
      end
    end else if (evt.raw_byte) begin
      res.valid = 1'b1;
      res.addr  = raw_addr;
      res.data  = evt.data;
    end else if (evt.raw_inc) begin
      cur_next = cur + 32'd1;
    end

    if (evt.offset_load) begin
      ext_next = evt.value;
    end
  end

  // configuration and tracking registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_length <= '0;
      dest_base     <= '0;
      cur           <= '0;
      ext           <= '0;
      lowest        <= '1;
      highest       <= '0;
    end else begin
      cur     <= cur_next;
      ext     <= ext_next;
      lowest  <= lowest_next;
      highest <= highest_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_START:  window_start  <= cfg_data;
          CFG_WINDOW_LENGTH: window_length <= cfg_data;
          CFG_DEST_BASE:     dest_base     <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `HRWL_ASSERT_NXT(a_eos_clear, evt.eos, lowest == '1 && highest == '0 && cur == '0, "tracking not cleared at end of stream")

endmodule

/* sv/hex_record_window_loader_unit.sv */
// A result enters the output register when its item leaves the input register.
// One item per cycle unless out_ready stalls; input and output registers each hold one item.
// The per-item step (parser plus one 32-bit window subtract and compare) sets the cycle.
// Reset: synchronous rst clears parse state, address tracking and configuration registers.
// ----------------------------------------------------------------------------
// hex_record_window_loader_unit
// Parses S-record, Intel HEX and raw byte text and emits relocated memory writes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_record_window_loader_unit import hrwl_pkg::*; #(
  parameter int MEM_ADDR_BITS  = 26,
  parameter int MAX_LINE_CHARS = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        ch,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [ADDR_W-1:0] write_addr,
  output logic [7:0]        write_data,
  output logic [32:0]       span,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic       s0_valid;
  logic       s0_req_type;
  logic [7:0] s0_ch;
  logic       s0_fire;
  hrwl_evt_t  evt;
  hrwl_res_t  res;

  // input stage handshake
  assign s0_fire  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || s0_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_req_type <= req_type;
      s0_ch       <= ch;
    end
  end

  // parser
  hrwl_parse #(
    .MAX_LINE_CHARS(MAX_LINE_CHARS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (s0_fire),
    .req_type (s0_req_type),
    .ch       (s0_ch),
    .evt      (evt)
  );

  // address unit
  hrwl_addr #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s0_fire) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && res.valid) begin
      kind       <= res.kind;
      write_addr <= res.addr;
      write_data <= res.data;
      span       <= res.span;
    end
  end

  `HRWL_ASSERT_NXT(a_eos_report, s0_fire && s0_req_type, out_valid && kind, "end of stream gave no report")
  `HRWL_ASSERT_NXT(a_out_drain, !s0_fire && !(out_valid && !out_ready), !out_valid, "result shown with no item")

endmodule

/* bench/hrwl_tb_pkg.sv */
// ----------------------------------------------------------------------------
// hrwl_tb_pkg
// Request and result codes shared by the loader testbench modules
// ----------------------------------------------------------------------------
package hrwl_tb_pkg;

  // input item request codes
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // result item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

endpackage

/* bench/hrwl_write_checker.sv */
// ----------------------------------------------------------------------------
// hrwl_write_checker
// Follows the input, output and register ports of the hex record window
// loader, parses the accepted text itself and compares every memory write
// and span report against its own prediction, oldest first
// ----------------------------------------------------------------------------
module hrwl_write_checker import hrwl_pkg::*, hrwl_tb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        ch,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              kind,
  input  logic [ADDR_W-1:0] write_addr,
  input  logic [7:0]        write_data,
  input  logic [32:0]       span,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CHARS = 200;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [32:0]       span;
  } loader_result_t;

  loader_result_t due_results[$];
  loader_result_t want;
  int             errs = 0;

  // window registers
  logic [31:0]       win_start;
  logic [31:0]       win_len;
  logic [ADDR_W-1:0] dest;

  // parse and tracking state
  logic [3:0]  line_phase;
  logic [2:0]  rec_form;
  logic [8:0]  line_pos;
  logic [7:0]  bytes_left;
  logic [7:0]  rec_type;
  logic [3:0]  nib;
  logic [31:0] acc;
  logic [31:0] cur_addr;
  logic [31:0] ext_off;
  logic [31:0] lo_addr;
  logic [31:0] hi_addr;

  // value of a hex character, bit 4 set for anything else
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = 8'd16;
    end
    return v[4:0];
  endfunction

  // character position of the first data digit
  function automatic logic [8:0] data_first(input logic [2:0] f);
    case (f)
      FM_S1:   return 9'd8;
      FM_S2:   return 9'd10;
      FM_S3:   return 9'd12;
      default: return 9'd9;
    endcase
  endfunction

  task automatic clear_line_state();
    line_phase = PH_START;
    rec_form   = FM_NONE;
    line_pos   = '0;
    bytes_left = '0;
    rec_type   = '0;
    nib        = '0;
    acc        = '0;
  endtask

  // raw lines advance the address at every line end
  task automatic close_line();
    if (rec_form == FM_RAW) cur_addr = cur_addr + 32'd1;
    clear_line_state();
  endtask

  task automatic push_write(input logic [ADDR_W-1:0] a, input logic [7:0] d);
    loader_result_t r;
    r.kind = KIND_WRITE;
    r.addr = a;
    r.data = d;
    r.span = '0;
    due_results.push_back(r);
  endtask

  // span of tracked addresses, then back to a clean stream
  task automatic report_span();
    loader_result_t r;
    r.kind = KIND_SPAN;
    r.addr = '0;
    r.data = '0;
    r.span = (hi_addr > lo_addr) ? ({1'b0, hi_addr} - {1'b0, lo_addr} + 33'd1) : 33'd0;
    due_results.push_back(r);
    clear_line_state();
    cur_addr = '0;
    ext_off  = '0;
    lo_addr  = '1;
    hi_addr  = '0;
  endtask

  // one record data byte, written only inside the window
  task automatic load_byte(input logic [7:0] d);
    logic [31:0] a;
    logic [31:0] off;
    a   = cur_addr;
    off = a - win_start;
    if (a >= win_start && off < win_len) begin
      push_write(off[ADDR_W-1:0] + dest, d);
      if (a < lo_addr) lo_addr = a;
      if (a > hi_addr) hi_addr = a;
    end
    cur_addr = a + 32'd1;
  endtask

  // one text character other than a line end
  task automatic parse_char(input logic [7:0] c);
    logic [8:0]  p;
    logic [8:0]  first;
    logic [8:0]  rel;
    logic [4:0]  h;
    logic [31:0] sum;
    logic        is_ihex;
    logic [7:0]  hdr;
    p     = line_pos;
    first = data_first(rec_form);
    case (line_phase)
      PH_START: begin
        if (c == CH_S) begin
          line_phase = PH_SSEL;
        end else if (c == CH_COLON) begin
          rec_form   = FM_IHEX;
          line_phase = PH_COUNT;
        end else if (c == CH_HASH) begin
          rec_form   = FM_RAW;
          line_phase = PH_RAW;
        end else begin
          line_phase = PH_SKIP;
        end
      end
      PH_SSEL: begin
        if (c == CH_ONE) rec_form = FM_S1;
        else if (c == CH_TWO) rec_form = FM_S2;
        else if (c == CH_THREE) rec_form = FM_S3;
        line_phase = (rec_form == FM_NONE) ? PH_SKIP : PH_COUNT;
      end
      PH_SKIP: ;
      default: begin
        h = nibble_of(c);
        if (h[4]) begin
          line_phase = PH_SKIP;
        end else begin
          sum     = {acc[27:0], h[3:0]};
          is_ihex = (rec_form == FM_IHEX);
          acc     = sum;
          case (line_phase)
            PH_COUNT: begin
              if (p == (is_ihex ? 9'd2 : 9'd3)) begin
                bytes_left = sum[7:0];
                acc        = '0;
                line_phase = PH_ADDR;
              end
            end
            PH_ADDR: begin
              if (p == first - (is_ihex ? 9'd3 : 9'd1)) begin
                cur_addr = sum;
                acc      = '0;
                hdr      = {5'd0, rec_form} + 8'd2;
                if (is_ihex) begin
                  line_phase = PH_TYPE;
                end else if (bytes_left > hdr) begin
                  bytes_left = bytes_left - hdr;
                  line_phase = PH_DATA;
                end else begin
                  bytes_left = '0;
                  line_phase = PH_SKIP;
                end
              end
            end
            PH_TYPE: begin
              if (p == 9'd8) begin
                rec_type = sum[7:0];
                acc      = '0;
                if (rec_type == IT_DATA) begin
                  cur_addr   = cur_addr + ext_off;
                  line_phase = (bytes_left != 8'd0) ? PH_DATA : PH_SKIP;
                end else if (rec_type == IT_SEGMENT || rec_type == IT_LINEAR) begin
                  line_phase = PH_OFFSET;
                end else begin
                  line_phase = PH_SKIP;
                end
              end
            end
            PH_DATA: begin
              rel = p - first;
              if (!rel[0]) begin
                nib = h[3:0];
              end else begin
                load_byte({nib, h[3:0]});
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) line_phase = PH_SKIP;
              end
            end
            PH_OFFSET: begin
              if (p == 9'd12) begin
                ext_off = (rec_type == IT_SEGMENT) ? {12'd0, sum[15:0], 4'd0}
                                                   : {sum[15:0], 16'd0};
                line_phase = PH_SKIP;
              end
            end
            PH_RAW: begin
              if (p == 9'd1) begin
                nib = h[3:0];
              end else begin
                push_write(cur_addr[ADDR_W-1:0] + dest, {nib, h[3:0]});
                line_phase = PH_SKIP;
              end
            end
            default: line_phase = PH_SKIP;
          endcase
        end
      end
    endcase
    line_pos = p + 9'd1;
    // an overlong line ends by itself
    if (line_pos >= LINE_CHARS - 1) close_line();
  endtask

  task automatic compare_field(input string field, input logic [32:0] exp_v,
                               input logic [32:0] got_v);
    if (got_v !== exp_v) begin
      errs++;
      $error("%s: expected %0h, actual %0h", field, exp_v, got_v);
    end
  endtask

  // follow the ports on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      win_start = '0;
      win_len   = '0;
      dest      = '0;
      clear_line_state();
      cur_addr  = '0;
      ext_off   = '0;
      lo_addr   = '1;
      hi_addr   = '0;
      due_results.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_START:  win_start = cfg_data;
          CFG_WINDOW_LENGTH: win_len   = cfg_data;
          CFG_DEST_BASE:     dest      = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && in_ready) begin
        if (req_type == REQ_EOS) report_span();
        else if (ch == CH_CR || ch == CH_LF) close_line();
        else parse_char(ch);
      end
      // accepted result item
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errs++;
          $error("result with nothing due: kind %0h addr %0h data %0h span %0h",
                 kind, write_addr, write_data, span);
        end else begin
          want = due_results.pop_front();
          compare_field("kind", 33'(want.kind), 33'(kind));
          compare_field("write_addr", 33'(want.addr), 33'(write_addr));
          compare_field("write_data", 33'(want.data), 33'(write_data));
          compare_field("span", want.span, span);
        end
      end
    end
    pending    <= due_results.size();
    mismatches <= errs;
  end

endmodule

/* bench/tb_hex_record_window_loader_unit.sv */
// ----------------------------------------------------------------------------
// tb_hex_record_window_loader_unit
// Feeds S-record, Intel HEX, raw byte and junk text through the loader under
// several window settings, with random gaps on both channels; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_hex_record_window_loader_unit import hrwl_pkg::*, hrwl_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_CHARS = 160;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              req_type  = REQ_CHAR;
  logic [7:0]        ch        = 8'd0;
  logic              out_ready = 1'b0;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = CFG_WINDOW_START;
  logic [31:0]       cfg_data  = 32'd0;
  logic              in_ready;
  logic              out_valid;
  logic              kind;
  logic [ADDR_W-1:0] write_addr;
  logic [7:0]        write_data;
  logic [32:0]       span;

  int          mismatches;
  int          pending;
  int          sent         = 0;
  int          stall_cycles = 0;
  bit          steady       = 1'b0;
  logic [31:0] cur_ws       = '0;
  logic [31:0] cur_wl       = '0;
  logic [31:0] gen_offset   = '0;

  hex_record_window_loader_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .write_addr (write_addr),
    .write_data (write_data),
    .span       (span),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  hrwl_write_checker u_write_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .write_addr (write_addr),
    .write_data (write_data),
    .span       (span),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 24);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one input item, held until accepted
  task automatic send(input logic rt, input logic [7:0] c);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    ch       <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // a text line, optionally cut short or with one non-hex character
  task automatic send_line(input string s, input bit broken);
    int         cut;
    int         bad;
    logic [7:0] junk;
    cut  = s.len();
    bad  = -1;
    junk = "G";
    if (broken && s.len() > 1) begin
      if ($urandom_range(0, 1) == 1) cut = $urandom_range(1, s.len() - 1);
      else bad = $urandom_range(1, s.len() - 1);
    end
    for (int i = 0; i < cut; i++) begin
      if (i == bad) begin
        junk = 8'($urandom_range(0, 255));
        while ((junk >= "0" && junk <= "9") || (junk >= "a" && junk <= "f") ||
               (junk >= "A" && junk <= "F")) junk = 8'($urandom_range(0, 255));
        send(REQ_CHAR, junk);
      end else begin
        send(REQ_CHAR, s[i]);
      end
    end
    // CR, LF or both
    case ($urandom_range(0, 2))
      0: send(REQ_CHAR, CH_CR);
      1: send(REQ_CHAR, CH_LF);
      default: begin
        send(REQ_CHAR, CH_CR);
        send(REQ_CHAR, CH_LF);
      end
    endcase
  endtask

  // let every due result drain and the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] ws, input logic [31:0] wl,
                            input logic [ADDR_W-1:0] db);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WINDOW_START;
    cfg_data  <= ws;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_data  <= wl;
    @(posedge clk);
    cfg_index <= CFG_DEST_BASE;
    cfg_data  <= {{(32 - ADDR_W){1'b0}}, db};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_ws = ws;
    cur_wl = wl;
  endtask

  // two hex digits in either case
  function automatic string hexb(input logic [7:0] v);
    return ($urandom_range(0, 1) == 1) ? $sformatf("%02x", v) : $sformatf("%02X", v);
  endfunction

  function automatic string hex16(input logic [15:0] v);
    return {hexb(v[15:8]), hexb(v[7:0])};
  endfunction

  function automatic string rand_bytes(input int n);
    string s;
    s = "";
    repeat (n) s = {s, hexb(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  // source address mostly close to the window edges
  function automatic logic [31:0] near_window();
    logic [31:0] reach;
    reach = (cur_wl > 60) ? 32'd68 : cur_wl + 32'd8;
    if ($urandom_range(0, 7) == 0) return $urandom();
    return cur_ws + $urandom_range(0, reach) - 32'd4;
  endfunction

  function automatic string s_line(input int d, input logic [7:0] cnt,
                                   input logic [31:0] addr, input int n);
    string s;
    s = {$sformatf("S%0d", d), hexb(cnt)};
    for (int b = d; b >= 0; b--) s = {s, hexb(addr[8*b +: 8])};
    return {s, rand_bytes(n), hexb(8'($urandom_range(0, 255)))};
  endfunction

  function automatic string i_line(input logic [7:0] cnt, input logic [15:0] a16,
                                   input logic [7:0] rt, input string payload);
    return {":", hexb(cnt), hex16(a16), hexb(rt), payload,
            hexb(8'($urandom_range(0, 255)))};
  endfunction

  // one random line or end of stream
  task automatic random_line();
    int          r;
    int          n;
    int          d;
    logic [7:0]  cnt;
    logic [15:0] v;
    logic [31:0] t;
    bit          broken;
    r      = $urandom_range(0, 99);
    broken = ($urandom_range(0, 6) == 0);
    if (r < 40) begin
      // motorola data record, sometimes with a bad count
      d   = $urandom_range(1, 3);
      n   = $urandom_range(0, 6);
      cnt = 8'(n + d + 2);
      case ($urandom_range(0, 9))
        0: cnt = 8'($urandom_range(0, d + 2));
        1: cnt = 8'(cnt + $urandom_range(1, 3));
        default: ;
      endcase
      send_line(s_line(d, cnt, near_window(), n), broken);
    end else if (r < 62) begin
      // intel data record, often after an offset record
      t = near_window();
      n = $urandom_range(0, 9);
      if (n < 4) begin
        v = t[31:16];
        send_line(i_line(8'd2, 16'($urandom()), IT_LINEAR, hex16(v)), broken);
        gen_offset = {v, 16'd0};
      end else if (n < 6) begin
        v = 16'($urandom());
        send_line(i_line(8'd2, 16'($urandom()), IT_SEGMENT, hex16(v)), broken);
        gen_offset = {12'd0, v, 4'd0};
      end
      t   = t - gen_offset;
      n   = $urandom_range(0, 6);
      cnt = 8'(n);
      if ($urandom_range(0, 9) == 0) cnt = 8'($urandom_range(0, 9));
      send_line(i_line(cnt, t[15:0], IT_DATA, rand_bytes(n)), $urandom_range(0, 6) == 0);
    end else if (r < 74) begin
      send_line({"#", hexb(8'($urandom_range(0, 255)))}, broken);
    end else if (r < 82) begin
      // junk bytes of any value
      n = $urandom_range(1, 24);
      repeat (n) send(REQ_CHAR, 8'($urandom_range(0, 255)));
      send(REQ_CHAR, CH_LF);
    end else if (r < 85) begin
      send(REQ_EOS, 8'($urandom_range(0, 255)));
      gen_offset = '0;
    end else if (r < 90) begin
      // record longer than a line may be
      send_line(s_line(1, 8'hFF, near_window(), $urandom_range(96, 120)), 1'b0);
    end else if (r < 95) begin
      // intel record of any type
      send_line(i_line(8'($urandom_range(0, 4)), 16'($urandom()), 8'($urandom()),
                       rand_bytes($urandom_range(0, 4))), broken);
    end else begin
      // S followed by anything
      send_line({$sformatf("S%c", $urandom_range(33, 126)), rand_bytes(3)}, 1'b0);
    end
  endtask

  task automatic run_traffic(input int budget);
    int start;
    start = sent;
    while (sent - start < budget) random_line();
    send(REQ_EOS, 8'($urandom_range(0, 255)));
    gen_offset = '0;
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // window of every address but the top one, destination wraps
    set_window(32'h0000_0000, 32'hFFFF_FFFF, 26'h3FF_FFFF);
    send_line("S1060010A1b2C3FF", 1'b0);
    send_line("S207FFFFFF0011EE5A", 1'b0);
    // s3 record crossing the top of the address space
    send_line("S309FFFFFFFE0102030400", 1'b0);
    // count leaves no data
    send_line("S1030000", 1'b0);
    // short record ending in half a byte
    send_line("S10A0020AB1", 1'b0);
    // non-hex character inside the data
    send_line("S1060030A1G2", 1'b0);
    // unknown line starts
    send_line("S5030000", 1'b0);
    send_line("Q:1234", 1'b0);
    // linear offset, data, segment offset, end record
    send_line(":02000004ABCD2E", 1'b0);
    send_line(":0300100001fF20CC", 1'b0);
    send_line(":020000021234B6", 1'b0);
    send_line(":00000001FF", 1'b0);
    // raw byte lines, complete, empty and broken
    send_line("#5a", 1'b0);
    send_line("#", 1'b0);
    send_line("#G1", 1'b0);
    send(REQ_EOS, 8'hFF);
    run_traffic(PHASE_CHARS);
    settle();

    for (int ph = 1; ph <= 5; ph++) begin
      steady <= (ph == 2);
      case (ph)
        1: set_window(32'h0000_1000, 32'h0000_0040, 26'h000_0123);
        2: set_window(32'hFFFF_FF00, 32'hFFFF_FFFF, 26'h000_0000);
        3: set_window(32'h0000_0000, 32'h0000_0000, 26'($urandom()));
        4: set_window($urandom(), $urandom_range(1, 64), 26'($urandom()));
        default: set_window(32'h0000_0001, 32'h0000_0001, 26'h3FF_FFFF);
      endcase
      run_traffic(PHASE_CHARS);
      settle();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
